/* sv/bmg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmg_pkg
// Shared constants, types and tables for the Box-Muller Gaussian pair unit.
// ----------------------------------------------------------------------------
package bmg_pkg;

  localparam int LogFracBits = 20;
  localparam int CordicSteps = 20;
  localparam int SqrtSteps   = 24;   // 48-bit radicand, two bits a step
  localparam int ZW          = 34;   // CORDIC angle, 2^-32 turn units
  localparam int CW          = 26;   // CORDIC x/y, Q.20 with headroom

  localparam logic [31:0] TwoLn2Q30   = 32'd1488522236;
  localparam logic [31:0] InvGainQ30  = 32'd652032874;
  localparam logic [24:0] EpsLsb      = 25'd17;
  localparam logic [29:0] LogLimit    = 30'(24) << LogFracBits;

  // log stage payload: mantissa Q1.30, integer part and fraction bits
  typedef struct packed {
    logic [30:0] m;
    logic [4:0]  p;
    logic [19:0] frac;
    logic [15:0] ang;
  } log_cell_t;

  typedef struct packed {
    logic [47:0] rem;
    logic [23:0] res;
    logic [15:0] ang;
  } sqrt_cell_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           q;
  } cordic_cell_t;

  function automatic logic [31:0] atan_turn32(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;  5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;  5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;   5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;   5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;    5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;     5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;     5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;       5'd19: v = 32'd1304;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* sv/bmg_log_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmg_log_cell
// One fraction bit of log2 by squaring the mantissa; registered.
// ----------------------------------------------------------------------------
module bmg_log_cell import bmg_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  log_cell_t d,
  output log_cell_t q
);

  logic [61:0] sq;
  log_cell_t   q_nxt;

  always_comb begin
    sq = 62'(d.m) * 62'(d.m);
    q_nxt = d;
    q_nxt.frac = {d.frac[18:0], 1'b0};
    if (sq[61]) begin
      q_nxt.m = sq[61:31];
      q_nxt.frac[0] = 1'b1;
    end else begin
      q_nxt.m = sq[60:30];
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_nxt;
  end

endmodule

/* sv/bmg_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmg_sqrt_cell
// One restoring square-root step: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module bmg_sqrt_cell import bmg_pkg::*; #(
  parameter int Step = 0
) (
  input  logic       clk,
  input  logic       en,
  input  sqrt_cell_t d,
  output sqrt_cell_t q
);

  localparam int Sh = 2 * (SqrtSteps - 1 - Step);

  logic [47:0] trial;
  sqrt_cell_t  q_nxt;

  always_comb begin
    trial = ((48'(d.res) << 2) | 48'd1) << Sh;
    q_nxt = d;
    if (d.rem >= trial) begin
      q_nxt.rem = d.rem - trial;
      q_nxt.res = {d.res[22:0], 1'b1};
    end else begin
      q_nxt.res = {d.res[22:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_nxt;
  end

endmodule

/* sv/bmg_cordic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmg_cordic_cell
// One CORDIC rotation step with a fixed shift and arctangent.
// ----------------------------------------------------------------------------
module bmg_cordic_cell import bmg_pkg::*; #(
  parameter int Step = 0
) (
  input  logic         clk,
  input  logic         en,
  input  cordic_cell_t d,
  output cordic_cell_t q
);

  localparam logic [4:0] StepIdx = 5'(Step);

  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] at;
  cordic_cell_t         q_nxt;

  always_comb begin
    dx = d.y >>> Step;
    dy = d.x >>> Step;
    at = $signed({2'b00, atan_turn32(StepIdx)});
    q_nxt = d;
    if (!d.z[ZW-1]) begin
      q_nxt.x = d.x - dx;
      q_nxt.y = d.y + dy;
      q_nxt.z = d.z - at;
    end else begin
      q_nxt.x = d.x + dx;
      q_nxt.y = d.y - dy;
      q_nxt.z = d.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_nxt;
  end

endmodule

/* sv/box_muller_gaussian_pair_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_muller_gaussian_pair_unit
// Fixed-point Box-Muller: uniform pair in, two Q3.12 normal samples out.
// ----------------------------------------------------------------------------
// Takes one beat per clock and returns one beat per input, in order. The
// data path is a chain of 68 register cells (normalize, 20 log cells, scale
// multiply, 24 square-root cells, gain multiply, 20 CORDIC cells, output
// fold). The whole chain advances when the output stage is empty or being
// drained, so backpressure stalls it in place.
module box_muller_gaussian_pair_unit import bmg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [23:0] radius_fraction, [39:24] angle_fraction
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [15:0] gauss_cos, [31:16] gauss_sin
);

  localparam int Depth = 1 + LogFracBits + 1 + SqrtSteps + 1 + CordicSteps + 1;

  logic [Depth-1:0] vld_r, vld_nxt;
  logic             adv;

  assign adv       = !vld_r[Depth-1] || out_tready;
  assign in_tready = adv;
  assign out_tvalid = vld_r[Depth-1];

  always_comb begin
    vld_nxt = {vld_r[Depth-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= vld_nxt;
  end

  // normalize
  logic [24:0] x_in;
  logic [4:0]  p;
  log_cell_t   log_c [LogFracBits+1];

  assign x_in = {1'b0, in_tdata[23:0]} + EpsLsb;
  always_comb begin
    p = '0;
    for (int k = 1; k < 25; k++) if (x_in[k]) p = 5'(k);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      log_c[0].m    <= 31'({6'b0, x_in} << (5'd30 - p));
      log_c[0].p    <= p;
      log_c[0].frac <= '0;
      log_c[0].ang  <= in_tdata[39:24];
    end
  end

  for (genvar g = 0; g < LogFracBits; g++) begin : g_log
    bmg_log_cell u_cell (.clk(clk), .en(adv), .d(log_c[g]), .q(log_c[g+1]));
  end

  // -2 ln(u1) in Q.20
  logic [29:0] lg, t;
  logic [61:0] s_prod;
  logic [47:0] s_r;
  logic [15:0] ang_s_r;

  assign lg = 30'({log_c[LogFracBits].p, log_c[LogFracBits].frac});
  assign t  = (lg >= LogLimit) ? '0 : LogLimit - lg;
  assign s_prod = 62'(t) * 62'(TwoLn2Q30) + (62'd1 << 29);

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r     <= 48'(s_prod[61:30]) << 20;
      ang_s_r <= log_c[LogFracBits].ang;
    end
  end

  sqrt_cell_t sq_c [SqrtSteps+1];
  always_comb begin
    sq_c[0].rem = s_r;
    sq_c[0].res = '0;
    sq_c[0].ang = ang_s_r;
  end

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    bmg_sqrt_cell #(.Step(g)) u_cell (.clk(clk), .en(adv), .d(sq_c[g]), .q(sq_c[g+1]));
  end

  // gain precompensation and quadrant fold
  logic [55:0] gx;
  logic [15:0] a;
  logic [1:0]  qd;
  logic [15:0] resid;
  cordic_cell_t cc [CordicSteps+1];

  assign a  = sq_c[SqrtSteps].ang;
  assign qd = 2'((a + 16'h2000) >> 14);
  assign resid = a - {qd, 14'b0};
  assign gx = 56'(sq_c[SqrtSteps].res) * 56'(InvGainQ30) + (56'd1 << 29);

  always_ff @(posedge clk) begin
    if (adv) begin
      cc[0].x <= $signed(CW'(gx[55:30]));
      cc[0].y <= '0;
      cc[0].z <= $signed({{2{resid[15]}}, resid, 16'b0});
      cc[0].q <= qd;
    end
  end

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
    bmg_cordic_cell #(.Step(g)) u_cell (.clk(clk), .en(adv), .d(cc[g]), .q(cc[g+1]));
  end

  function automatic logic [15:0] to_q312(input logic signed [CW:0] v);
    logic signed [CW:0] r;
    r = (v + (CW+1)'(128)) >>> 8;
    if (r > 32767) return 16'h7fff;
    if (r < -32768) return 16'h8000;
    return r[15:0];
  endfunction

  logic signed [CW:0] fx, fy, ox, oy;
  assign fx = (CW+1)'(cc[CordicSteps].x);
  assign fy = (CW+1)'(cc[CordicSteps].y);
  always_comb begin
    unique case (cc[CordicSteps].q)
      2'd1: begin ox = -fy; oy = fx;  end
      2'd2: begin ox = -fx; oy = -fy; end
      2'd3: begin ox = fy;  oy = -fx; end
      default: begin ox = fx; oy = fy; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) out_tdata <= {to_q312(oy), to_q312(ox)};
  end

endmodule
